FILE: sv/smsu_pkg.sv
// ----------------------------------------------------------------------------
// smsu_pkg
// Shared types and constants of the sorted matrix search unit: field widths,
// register indexes and reset values, and the queued work word.
// ----------------------------------------------------------------------------
`default_nettype none

package smsu_pkg;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int LOAD_IDX_W = 4;

    // Widest store address over the whole parameter range (256 x 256)
    localparam int ADDR_MAX_W = 16;

    // Default matrix geometry
    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;
    localparam logic [CFG_W-1:0]     ROWS_RESET      = 5'd4;
    localparam logic [CFG_W-1:0]     COLS_RESET      = 5'd5;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Work queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified word of work
    typedef struct packed {
        logic                         is_search;
        logic [ADDR_MAX_W-1:0]        addr;
        logic signed [DATA_W-1:0]     data;
    } work_t;

    // Front to queue
    typedef struct packed {
        logic  valid;
        work_t work;
    } push_t;

    // Queue head to back
    typedef struct packed {
        logic  valid;
        work_t work;
    } head_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

FILE: sv/smsu_front.sv
// ----------------------------------------------------------------------------
// smsu_front
// Input side: takes words from the input channel, computes the store address
// of a load, drops loads outside the matrix and pushes the rest as work.
// ----------------------------------------------------------------------------
`default_nettype none

module smsu_front #(
    parameter int MAX_ROWS = smsu_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smsu_pkg::MAX_COLS_DEF
) (
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic                                    req_type,
    input  wire logic [smsu_pkg::LOAD_IDX_W-1:0]         load_row,
    input  wire logic [smsu_pkg::LOAD_IDX_W-1:0]         load_col,
    input  wire logic signed [smsu_pkg::DATA_W-1:0]      entry_value,
    input  wire logic signed [smsu_pkg::DATA_W-1:0]      search_key,
    input  wire smsu_pkg::qstat_t                        qstat,
    output smsu_pkg::push_t                              push
);

    logic        accept;
    logic        is_search;
    logic        in_range;
    logic [31:0] addr_full;

    // Stall while the work queue is full
    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    // Classify the word and place a load in the store
    assign is_search = (req_type == smsu_pkg::REQ_SEARCH);
    assign in_range  = (32'(load_row) < 32'(MAX_ROWS)) && (32'(load_col) < 32'(MAX_COLS));
    assign addr_full = 32'(load_row) * 32'(MAX_COLS) + 32'(load_col);

    // Push searches and in-range loads; drop the rest
    always_comb
    begin
        push.valid          = accept && (is_search || in_range);
        push.work.is_search = is_search;
        push.work.addr      = addr_full[smsu_pkg::ADDR_MAX_W-1:0];
        push.work.data      = is_search ? search_key : entry_value;
    end

endmodule

`default_nettype wire

FILE: sv/smsu_queue.sv
// ----------------------------------------------------------------------------
// smsu_queue
// Short work queue between the front and the search engine, so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module smsu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smsu_pkg::push_t   push,
    input  wire logic              pop,
    output smsu_pkg::head_t        head,
    output smsu_pkg::qstat_t       qstat
);

    smsu_pkg::work_t                 entries [smsu_pkg::QUEUE_DEPTH];
    logic [smsu_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [smsu_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [smsu_pkg::QCNT_W-1:0]     count_reg;
    logic [smsu_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign qstat.full  = (count_reg == smsu_pkg::QCNT_W'(smsu_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    assign do_push = push.valid && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    assign head.valid = !qstat.empty;
    assign head.work  = entries[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push.work;
        end
    end

endmodule

`default_nettype wire

FILE: sv/smsu_back.sv
// ----------------------------------------------------------------------------
// smsu_back
// Search engine: holds the matrix store and the geometry registers, writes
// loads, and runs the row search and then the column search one probe at a
// time against the registered store reads. Drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smsu_back #(
    parameter int MAX_ROWS = smsu_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smsu_pkg::MAX_COLS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wen,
    input  wire logic [smsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smsu_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire smsu_pkg::head_t                   head,
    output logic                                   pop,
    output logic                                   busy,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   found
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = smsu_pkg::CFG_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ROW_RD  = 3'd1;
    localparam logic [2:0] S_ROW_CMP = 3'd2;
    localparam logic [2:0] S_COL_RD  = 3'd3;
    localparam logic [2:0] S_COL_CMP = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    logic signed [smsu_pkg::DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]                      rows_reg;
    logic [CW-1:0]                      cols_reg;
    logic [CW-1:0]                      nr;
    logic [CW-1:0]                      nc;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [CW-1:0]                      lo_reg;
    logic [CW-1:0]                      lo_next;
    logic [CW-1:0]                      hip_reg;
    logic [CW-1:0]                      hip_next;
    logic [CW-1:0]                      mid_reg;
    logic [CW-1:0]                      mid_next;
    logic [CW-1:0]                      row_reg;
    logic [CW-1:0]                      row_next;
    logic signed [smsu_pkg::DATA_W-1:0] key_reg;
    logic                               res_reg;
    logic                               res_next;
    logic                               out_valid_reg;
    logic                               found_reg;

    logic [CW:0]                        mid_sum;
    logic [CW-1:0]                      mid_c;
    logic [CW-1:0]                      row_sel;
    logic [CW-1:0]                      col_a;
    logic [31:0]                        addr_a_full;
    logic [31:0]                        addr_b_full;
    logic [AW-1:0]                      addr_a;
    logic [AW-1:0]                      addr_b;
    logic signed [smsu_pkg::DATA_W-1:0] rd_a_reg;
    logic signed [smsu_pkg::DATA_W-1:0] rd_b_reg;
    logic                               mem_wr;
    logic                               slot_free;

    // Saturate the geometry to the store size
    assign nr = (32'(rows_reg) > 32'(MAX_ROWS)) ? CW'(MAX_ROWS) : rows_reg;
    assign nc = (32'(cols_reg) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : cols_reg;

    // Midpoint of the half-open range [lo, hip)
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hip_reg} - 1'b1;
    assign mid_c   = mid_sum[CW:1];

    // Probe addresses: first and last entry of a row, or one column of a row
    assign row_sel     = (state_reg == S_ROW_RD) ? mid_c : row_reg;
    assign col_a       = (state_reg == S_COL_RD) ? mid_c : '0;
    assign addr_a_full = 32'(row_sel) * 32'(MAX_COLS) + 32'(col_a);
    assign addr_b_full = 32'(row_sel) * 32'(MAX_COLS) + 32'(nc - 1'b1);
    assign addr_a      = addr_a_full[AW-1:0];
    assign addr_b      = addr_b_full[AW-1:0];

    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign mem_wr    = pop && !head.work.is_search;
    assign busy      = (state_reg != S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;

    // Sequence the two binary searches
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hip_next   = hip_reg;
        mid_next   = mid_reg;
        row_next   = row_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && head.work.is_search)
                begin
                    if (nr == '0 || nc == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hip_next   = nr;
                        state_next = S_ROW_RD;
                    end
                end
            end
            S_ROW_RD:
            begin
                if (lo_reg >= hip_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    row_next   = mid_c;
                    state_next = S_ROW_CMP;
                end
            end
            S_ROW_CMP:
            begin
                if (key_reg >= rd_a_reg && key_reg <= rd_b_reg)
                begin
                    lo_next    = '0;
                    hip_next   = nc;
                    state_next = S_COL_RD;
                end
                else
                begin
                    if (key_reg < rd_a_reg)
                    begin
                        hip_next = row_reg;
                    end
                    else
                    begin
                        lo_next = row_reg + 1'b1;
                    end
                    state_next = S_ROW_RD;
                end
            end
            S_COL_RD:
            begin
                if (lo_reg >= hip_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    mid_next   = mid_c;
                    state_next = S_COL_CMP;
                end
            end
            S_COL_CMP:
            begin
                if (rd_a_reg == key_reg)
                begin
                    res_next   = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    if (key_reg < rd_a_reg)
                    begin
                        hip_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    state_next = S_COL_RD;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state, geometry registers and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= smsu_pkg::ROWS_RESET;
            cols_reg      <= smsu_pkg::COLS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen && cfg_index == smsu_pkg::REG_ROWS_IN_USE)
            begin
                rows_reg <= cfg_wdata;
            end
            if (cfg_wen && cfg_index == smsu_pkg::REG_COLS_IN_USE)
            begin
                cols_reg <= cfg_wdata;
            end
            if (state_reg == S_RESULT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hip_reg <= hip_next;
        mid_reg <= mid_next;
        row_reg <= row_next;
        res_reg <= res_next;
        if (pop)
        begin
            key_reg <= head.work.data;
        end
        if (state_reg == S_RESULT && slot_free)
        begin
            found_reg <= res_reg;
        end
    end

    // Matrix store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[head.work.addr[AW-1:0]] <= head.work.data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

endmodule

`default_nettype wire

FILE: sv/sorted_matrix_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_matrix_search_unit
// Membership search over a row-major sorted matrix of signed 32-bit entries.
// ----------------------------------------------------------------------------
// Words enter a two-deep work queue whenever it has room. A load is then
// written into the matrix store when the search engine takes it, and gives
// no result. A search runs a binary search over the rows and then one over
// the columns of the bracketing row; every probe waits on a registered read
// of the matrix store. It ends when the key is found, when the range in
// search is empty, or at once when no rows or columns are in use, and then
// loads the result register. One word is worked at a time; the next search
// starts when the previous result sits in the output register. Write
// rows_in_use and cols_in_use only while the unit is idle; the user must
// read entries only after load, as the unit itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_matrix_search_unit #(
    parameter int MAX_ROWS = smsu_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smsu_pkg::MAX_COLS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [smsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [smsu_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                req_type,
    input  wire logic [smsu_pkg::LOAD_IDX_W-1:0]     load_row,
    input  wire logic [smsu_pkg::LOAD_IDX_W-1:0]     load_col,
    input  wire logic signed [smsu_pkg::DATA_W-1:0]  entry_value,
    input  wire logic signed [smsu_pkg::DATA_W-1:0]  search_key,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found
);

    smsu_pkg::push_t  push;
    smsu_pkg::head_t  head;
    smsu_pkg::qstat_t qstat;
    logic             pop;
    logic             busy;

    // Accept and classify input words
    smsu_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .load_row    (load_row),
        .load_col    (load_col),
        .entry_value (entry_value),
        .search_key  (search_key),
        .qstat       (qstat),
        .push        (push)
    );

    // Buffer work between front and engine
    smsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    // Carry out loads and searches
    smsu_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found)
    );

    // The engine takes work only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("engine popped an empty work queue");

    // An empty queue never stalls the input
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !in_stall)
        else $error("input stalled with an empty work queue");

    // A busy engine does not take new work
    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pop)
        else $error("engine popped work while a search was running");

    // A popped search keeps the engine busy in the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.work.is_search) |=> busy)
        else $error("search popped but engine not busy");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted matrix search unit.
// ----------------------------------------------------------------------------
// An initial block plans the whole run as a queue of steps: words (loads and
// searches), register writes and drains. A clocked driver feeds the words
// through the valid/stall handshake and keeps its own copy of the matrix and
// the geometry, so every accepted search pushes the answer it should give. A
// clocked monitor pops that answer for each result word and compares it.
// The matrix is loaded completely before the first search, so no search ever
// reads an entry that was never written. Both sides idle in random bursts;
// the receiver also holds off for long stretches so that the unit backs up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_STEPS    = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int TARGET_WORDS  = 1650;

    localparam logic signed [smsu_pkg::DATA_W-1:0] KEY_MIN =
        {1'b1, {(smsu_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [smsu_pkg::DATA_W-1:0] KEY_MAX =
        {1'b0, {(smsu_pkg::DATA_W-1){1'b1}}};

    typedef enum logic [1:0] {STEP_WORD, STEP_CFG, STEP_DRAIN} step_kind_t;

    typedef struct packed {
        step_kind_t                             kind;
        logic                                   req;
        logic [smsu_pkg::LOAD_IDX_W-1:0]        row;
        logic [smsu_pkg::LOAD_IDX_W-1:0]        col;
        logic signed [smsu_pkg::DATA_W-1:0]     value;
        logic signed [smsu_pkg::DATA_W-1:0]     key;
        logic [smsu_pkg::CFG_IDX_W-1:0]         cfg_idx;
        logic [smsu_pkg::CFG_W-1:0]             cfg_val;
    } plan_step_t;

    // DUT ports
    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_wen     = 1'b0;
    logic [smsu_pkg::CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [smsu_pkg::CFG_W-1:0]             cfg_wdata   = '0;
    logic                                   in_valid    = 1'b0;
    logic                                   in_stall;
    logic                                   req_type    = 1'b0;
    logic [smsu_pkg::LOAD_IDX_W-1:0]        load_row    = '0;
    logic [smsu_pkg::LOAD_IDX_W-1:0]        load_col    = '0;
    logic signed [smsu_pkg::DATA_W-1:0]     entry_value = '0;
    logic signed [smsu_pkg::DATA_W-1:0]     search_key  = '0;
    logic                                   out_valid;
    logic                                   out_stall   = 1'b0;
    logic                                   found;

    // Planned steps and the answers still owed by the unit
    plan_step_t                             pending_steps[$];
    bit                                     found_q[$];

    // Shadow of the matrix used while planning keys
    logic signed [smsu_pkg::DATA_W-1:0]
        plan_grid [smsu_pkg::MAX_ROWS_DEF][smsu_pkg::MAX_COLS_DEF];
    int                                     planned_words = 0;

    // Predictor state, updated as words and writes are accepted
    logic signed [smsu_pkg::DATA_W-1:0]
        grid [smsu_pkg::MAX_ROWS_DEF][smsu_pkg::MAX_COLS_DEF];
    logic [smsu_pkg::CFG_W-1:0]             rows_cfg = smsu_pkg::ROWS_RESET;
    logic [smsu_pkg::CFG_W-1:0]             cols_cfg = smsu_pkg::COLS_RESET;

    // Driver bookkeeping
    int                             quiet_cycles     = 0;
    int                             gap_left         = 0;
    bit                             sender_busy_mode = 1'b1;
    logic                           tail_calm        = 1'b0;
    int                             words_sent       = 0;
    int                             loads_sent       = 0;
    int                             searches_sent    = 0;
    int                             cfg_writes       = 0;
    int                             drains_done      = 0;

    // Receiver bookkeeping
    int                             stall_left       = 0;
    int                             hold_left        = 0;
    int                             holds_done       = 0;
    int                             recv_cycles      = 0;
    bit                             recv_busy_mode   = 1'b1;
    int                             results_seen     = 0;

    int                             err_count        = 0;
    int                             cycle_count      = 0;

    sorted_matrix_search_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .load_row    (load_row),
        .load_col    (load_col),
        .entry_value (entry_value),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Row search, then column search inside the bracketing row
    function automatic bit key_present(logic signed [smsu_pkg::DATA_W-1:0] key);
        int nr;
        int nc;
        int lo;
        int hi;
        int mid;
        int a;
        int b;
        int m;
        logic signed [smsu_pkg::DATA_W-1:0] first_v;
        logic signed [smsu_pkg::DATA_W-1:0] last_v;
        logic signed [smsu_pkg::DATA_W-1:0] v;
        nr = (rows_cfg > smsu_pkg::MAX_ROWS_DEF) ? smsu_pkg::MAX_ROWS_DEF : int'(rows_cfg);
        nc = (cols_cfg > smsu_pkg::MAX_COLS_DEF) ? smsu_pkg::MAX_COLS_DEF : int'(cols_cfg);
        if (nr == 0 || nc == 0)
            return 1'b0;
        lo = 0;
        hi = nr - 1;
        while (lo <= hi)
        begin
            mid     = lo + (hi - lo) / 2;
            first_v = grid[mid][0];
            last_v  = grid[mid][nc-1];
            if (key >= first_v && key <= last_v)
            begin
                a = 0;
                b = nc - 1;
                while (a <= b)
                begin
                    m = a + (b - a) / 2;
                    v = grid[mid][m];
                    if (v == key)
                        return 1'b1;
                    if (key < v)
                        b = m - 1;
                    else
                        a = m + 1;
                end
                return 1'b0;
            end
            if (key < first_v)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Planning helpers
    // ------------------------------------------------------------------
    task automatic add_load(int r, int c, logic signed [smsu_pkg::DATA_W-1:0] v);
        plan_step_t s;
        s       = '0;
        s.kind  = STEP_WORD;
        s.req   = smsu_pkg::REQ_LOAD;
        s.row   = r[smsu_pkg::LOAD_IDX_W-1:0];
        s.col   = c[smsu_pkg::LOAD_IDX_W-1:0];
        s.value = v;
        s.key   = $urandom;
        pending_steps.push_back(s);
        plan_grid[r][c] = v;
        planned_words++;
    endtask

    task automatic add_search(logic signed [smsu_pkg::DATA_W-1:0] k);
        plan_step_t s;
        s       = '0;
        s.kind  = STEP_WORD;
        s.req   = smsu_pkg::REQ_SEARCH;
        s.row   = smsu_pkg::LOAD_IDX_W'($urandom);
        s.col   = smsu_pkg::LOAD_IDX_W'($urandom);
        s.value = $urandom;
        s.key   = k;
        pending_steps.push_back(s);
        planned_words++;
    endtask

    task automatic add_cfg(logic [smsu_pkg::CFG_IDX_W-1:0] idx, int val);
        plan_step_t s;
        s         = '0;
        s.kind    = STEP_CFG;
        s.cfg_idx = idx;
        s.cfg_val = val[smsu_pkg::CFG_W-1:0];
        pending_steps.push_back(s);
    endtask

    task automatic add_drain();
        plan_step_t s;
        s      = '0;
        s.kind = STEP_DRAIN;
        pending_steps.push_back(s);
    endtask

    task automatic set_geometry(int rows, int cols);
        add_drain();
        add_cfg(smsu_pkg::REG_ROWS_IN_USE, rows);
        add_cfg(smsu_pkg::REG_COLS_IN_USE, cols);
    endtask

    // Load the top-left nr x nc block in ascending row-major order
    task automatic fill_sorted(int nr, int nc, bit pin_corners);
        longint span;
        longint stride;
        longint level;
        logic signed [smsu_pkg::DATA_W-1:0] v;
        span = 64'd4294967295 / (nr * nc + 1);
        case ($urandom_range(0, 2))
            0:       stride = 3;
            1:       stride = $urandom_range(1, 1000);
            default: stride = span;
        endcase
        if (stride > span)
            stride = span;
        level = -longint'(32'h8000_0000) + $urandom_range(0, 32'(stride));
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                level = level + $urandom_range(0, 32'(stride));
                v = level[smsu_pkg::DATA_W-1:0];
                if (pin_corners && r == 0 && c == 0)
                    v = KEY_MIN;
                if (pin_corners && r == nr - 1 && c == nc - 1)
                    v = KEY_MAX;
                add_load(r, c, v);
            end
        end
    endtask

    // Mostly keys that sit in the block, or just beside one
    function automatic logic signed [smsu_pkg::DATA_W-1:0] pick_key(int nr, int nc);
        int r;
        int c;
        logic signed [smsu_pkg::DATA_W-1:0] v;
        r = $urandom_range(0, nr - 1);
        c = $urandom_range(0, nc - 1);
        v = plan_grid[r][c];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return v;
            5:             return v + 1;
            6:             return v - 1;
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    default: return '0;
                endcase
            end
            default:       return $urandom;
        endcase
    endfunction

    // One geometry: refill, search, and mix in noise until the budget is spent
    task automatic run_geometry(int rows, int cols, int budget);
        int first_word;
        int nr;
        int nc;
        first_word = planned_words;
        nr = (rows > smsu_pkg::MAX_ROWS_DEF) ? smsu_pkg::MAX_ROWS_DEF : rows;
        nc = (cols > smsu_pkg::MAX_COLS_DEF) ? smsu_pkg::MAX_COLS_DEF : cols;
        set_geometry(rows, cols);
        while (planned_words - first_word < budget)
        begin
            if (nr == 0 || nc == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
                else
                    add_search($urandom);
            end
            else
            begin
                fill_sorted(nr, nc, $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0)
                    add_drain();
                repeat ($urandom_range(8, 30))
                begin
                    case ($urandom_range(0, 9))
                        0:       add_load($urandom_range(0, 15), $urandom_range(0, 15),
                                          $urandom);
                        1:       add_search($urandom);
                        default: add_search(pick_key(nr, nc));
                    endcase
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Plan the run, apply reset, and wait for the end
    // ------------------------------------------------------------------
    initial
    begin : run_control
        int waited;

        // Whole store first, with the extreme values at the corners
        fill_sorted(smsu_pkg::MAX_ROWS_DEF, smsu_pkg::MAX_COLS_DEF, 1'b1);

        // Reset geometry of 4 x 5
        add_search(KEY_MIN);
        add_search(KEY_MAX);
        add_search('0);
        add_search(plan_grid[3][4]);
        add_search(plan_grid[2][0]);
        add_search(plan_grid[1][2]);
        add_search(plan_grid[1][4] + 1);
        add_search(plan_grid[3][4] + 1);
        add_search(plan_grid[4][0]);
        add_search(plan_grid[0][5]);

        // Full geometry, then saturating values
        set_geometry(16, 16);
        add_search(KEY_MAX);
        add_search(plan_grid[8][7]);
        add_search(plan_grid[15][0] - 1);
        set_geometry(31, 31);
        add_search(KEY_MAX);
        add_search(plan_grid[7][9]);

        // Zero rows, zero columns: nothing is ever found
        set_geometry(0, 5);
        add_search(KEY_MIN);
        add_search(plan_grid[0][0]);
        set_geometry(9, 0);
        add_search(plan_grid[0][0]);

        // Smallest geometry
        set_geometry(1, 1);
        add_search(plan_grid[0][0]);
        add_search(plan_grid[0][0] + 1);

        // Unsorted contents inside the block in use
        set_geometry(3, 4);
        add_load(1, 1, KEY_MAX);
        add_load(2, 3, KEY_MIN);
        add_search(KEY_MAX);
        add_search(KEY_MIN);

        // Lopsided and over-range geometries, then random ones
        run_geometry(17, 3, 80);
        run_geometry(2, 16, 80);
        run_geometry(16, 16, 60);
        while (planned_words < TARGET_WORDS)
        begin
            run_geometry(($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                    : $urandom_range(1, 31),
                         ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                    : $urandom_range(1, 31),
                         $urandom_range(60, 160));
        end
        run_geometry($urandom_range(2, 8), $urandom_range(2, 8), 150);

        // Reset
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the plan to run out, then for the answers still owed
        while (pending_steps.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (found_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (found_q.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, found_q.size());
        end

        $display("Run covered %0d loads and %0d searches, %0d results checked, %0d reg writes.",
                 loads_sent, searches_sent, results_seen, cfg_writes);
        $display("Sender drained %0d times; receiver held off %0d times.",
                 drains_done, holds_done);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: accept into the predictor, then present the next step
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        plan_step_t head;
        logic       nxt_valid;
        logic       nxt_wen;
        bit         calm;
        nxt_valid = in_valid;
        nxt_wen   = 1'b0;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_wen   <= 1'b0;
            tail_calm <= 1'b0;
        end
        else
        begin
            calm = (pending_steps.size() < TAIL_STEPS);

            // Update the matrix copy or queue the answer for the accepted word
            if (in_valid && !in_stall)
            begin
                if (req_type == smsu_pkg::REQ_SEARCH)
                begin
                    found_q.push_back(key_present(search_key));
                    searches_sent++;
                end
                else
                begin
                    grid[load_row][load_col] = entry_value;
                    loads_sent++;
                end
                nxt_valid = 1'b0;
                words_sent++;
                if (words_sent % 100 == 0)
                    sender_busy_mode = ($urandom_range(0, 2) != 0);
            end

            // Count cycles with nothing in flight from our side
            if (nxt_valid || found_q.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;

            // Pick the next step once the previous word is gone
            if (!nxt_valid && gap_left != 0)
                gap_left--;
            else if (!nxt_valid && pending_steps.size() != 0)
            begin
                head = pending_steps[0];
                case (head.kind)
                    STEP_CFG:
                    begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            nxt_wen = 1'b1;
                            cfg_index <= head.cfg_idx;
                            cfg_wdata <= head.cfg_val;
                            if (head.cfg_idx == smsu_pkg::REG_ROWS_IN_USE)
                                rows_cfg = head.cfg_val;
                            else if (head.cfg_idx == smsu_pkg::REG_COLS_IN_USE)
                                cols_cfg = head.cfg_val;
                            cfg_writes++;
                            void'(pending_steps.pop_front());
                        end
                    end
                    STEP_DRAIN:
                    begin
                        if (quiet_cycles != 0)
                        begin
                            drains_done++;
                            void'(pending_steps.pop_front());
                        end
                    end
                    default:
                    begin
                        if (sender_busy_mode && !calm && $urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(1, 18) - 1;
                        else
                        begin
                            req_type    <= head.req;
                            load_row    <= head.row;
                            load_col    <= head.col;
                            entry_value <= head.value;
                            search_key  <= head.key;
                            nxt_valid = 1'b1;
                            void'(pending_steps.pop_front());
                        end
                    end
                endcase
            end

            in_valid  <= nxt_valid;
            cfg_wen   <= nxt_wen;
            tail_calm <= calm;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random bursts plus two long hold-offs
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : stall_results
        logic nxt_stall;
        int   hold_mark;
        nxt_stall = 1'b0;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            recv_cycles++;
            if (recv_cycles % 128 == 0)
                recv_busy_mode = ($urandom_range(0, 2) != 0);
            hold_mark = (holds_done == 0) ? 120 : 500;
            if (hold_left != 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (!tail_calm && holds_done < 2 && results_seen >= hold_mark)
            begin
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                nxt_stall = 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                nxt_stall = 1'b1;
            end
            else if (recv_busy_mode && !tail_calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                nxt_stall = 1'b1;
            end
            out_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest answer owed
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        bit want;
        if (!rst_n)
            results_seen <= 0;
        else if (out_valid && !out_stall)
        begin
            if (found_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none actual found=%0b",
                         $time, found);
            end
            else
            begin
                want = found_q.pop_front();
                if (found !== want)
                begin
                    err_count++;
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, want, found);
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d results owed", $time, found_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
